// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property failed");
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== rtl/core/emp_pkg.sv =====
// shared types and constants of the easing motion profile
package emp_pkg;

   localparam int POS_WIDTH       = 16;
   localparam int PHASE_FRAC_BITS = 16;
   localparam int PHASE_WIDTH     = PHASE_FRAC_BITS + 1;
   localparam int VEL_WIDTH       = POS_WIDTH + 8;
   localparam int MODE_WIDTH      = 3;
   localparam int DAMP_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [PHASE_WIDTH-1:0] PHASE_ONE  = PHASE_WIDTH'(1) << PHASE_FRAC_BITS;
   localparam logic [PHASE_WIDTH-1:0] PHASE_HALF = PHASE_WIDTH'(1) << (PHASE_FRAC_BITS - 1);

   localparam logic [MODE_WIDTH-1:0] CURVE_LINEAR       = 3'd0;
   localparam logic [MODE_WIDTH-1:0] CURVE_EASE_IN      = 3'd1;
   localparam logic [MODE_WIDTH-1:0] CURVE_EASE_OUT     = 3'd2;
   localparam logic [MODE_WIDTH-1:0] CURVE_EASE_IN_OUT  = 3'd3;
   localparam logic [MODE_WIDTH-1:0] CURVE_PROPORTIONAL = 3'd4;
   localparam logic [MODE_WIDTH-1:0] CURVE_SPRING       = 3'd5;

   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_POS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_POS    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CURVE_MODE = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DAMPING    = 2'd3;

   localparam logic signed [POS_WIDTH-1:0] START_POS_RESET = POS_WIDTH'(-384);
   localparam logic signed [POS_WIDTH-1:0] END_POS_RESET   = POS_WIDTH'(384);
   localparam logic [MODE_WIDTH-1:0]       CURVE_RESET     = CURVE_LINEAR;
   localparam logic [DAMP_WIDTH-1:0]       DAMPING_RESET   = 8'd179;

   typedef struct packed {
      logic                       func;
      logic [PHASE_FRAC_BITS-1:0] phase_step;
   } req_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] position;
      logic                        moving;
   } rsp_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] start_pos;
      logic signed [POS_WIDTH-1:0] end_pos;
      logic [MODE_WIDTH-1:0]       curve_mode;
      logic [DAMP_WIDTH-1:0]       damping;
   } cfg_type;

   // stage one result handed to the position stage
   typedef struct packed {
      logic                   func;
      logic                   moving;
      logic [PHASE_WIDTH-1:0] frac;
   } frac_type;

endpackage

// ===== rtl/core/emp_cos_rom.sv =====
// quarter-wave cosine table built at elaboration, with rounded index lookup
module emp_cos_rom #(
   parameter int ENTRIES = 256
) (
   input  logic [emp_pkg::PHASE_WIDTH-1:0] angle,
   output logic [emp_pkg::PHASE_WIDTH-1:0] cos_val
);

   localparam int PW          = emp_pkg::PHASE_WIDTH;
   localparam int IDX_WIDTH   = $clog2(ENTRIES + 1);
   localparam int SCALE_WIDTH = PW + IDX_WIDTH;
   localparam int ROUND_SHIFT = 30 - emp_pkg::PHASE_FRAC_BITS;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] TAYLOR_DIV [12] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
   };

   // 13-term series on q2.30 magnitudes, floored at zero
   function automatic logic [63:0] cos_q30(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [64:0] acc;
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      acc  = $signed({1'b0, term});
      for (int n = 0; n < 12; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if (n[0] == 1'b0) begin
            acc = acc - $signed({1'b0, term});
         end else begin
            acc = acc + $signed({1'b0, term});
         end
      end
      if (acc < 0) begin
         acc = '0;
      end
      return acc[63:0];
   endfunction

   logic [PW-1:0]          rom_w [ENTRIES+1];
   logic [SCALE_WIDTH-1:0] scaled;
   logic [IDX_WIDTH-1:0]   idx;

   for (genvar k = 0; k <= ENTRIES; k++) begin : g_entry
      localparam logic [63:0] ANGLE   = HALF_PI_Q30 * 64'(k) / 64'(ENTRIES);
      localparam logic [63:0] SERIES  = cos_q30(ANGLE);
      localparam logic [63:0] ROUNDED = (SERIES + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      localparam logic [63:0] ONE_EXT = 64'(emp_pkg::PHASE_ONE);
      assign rom_w[k] = (ROUNDED > ONE_EXT) ? emp_pkg::PHASE_ONE : ROUNDED[PW-1:0];
   end

   // nearest entry: (angle * entries + half) >> frac bits; angles up to one stay within the table
   assign scaled  = SCALE_WIDTH'(angle) * SCALE_WIDTH'(ENTRIES)
                  + SCALE_WIDTH'(emp_pkg::PHASE_HALF);
   assign idx     = IDX_WIDTH'(scaled >> emp_pkg::PHASE_FRAC_BITS);
   assign cos_val = rom_w[idx];

endmodule

// ===== rtl/core/emp_phase_stage.sv =====
// stage one: phase accumulate and clamp, curve fraction (cosine table for the eased curves)
module emp_phase_stage #(
   parameter int COS_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  emp_pkg::req_type                 req,
   input  logic [emp_pkg::MODE_WIDTH-1:0]   curve_mode,
   output emp_pkg::frac_type                frac_ff
);

   localparam int PW = emp_pkg::PHASE_WIDTH;

   logic [PW-1:0]     phase_ff;
   logic [PW-1:0]     phase_in;
   logic [PW:0]       phase_sum;
   logic [PW-1:0]     phase_adv;
   logic [PW-1:0]     fold_diff;
   logic [PW-1:0]     cos_arg;
   logic [PW-1:0]     cos_val;
   logic [PW-1:0]     half_diff;
   logic [PW:0]       half_sum;
   logic              first_half;
   emp_pkg::frac_type frac_in;

   assign phase_sum  = {1'b0, phase_ff} + (PW+1)'(req.phase_step);
   assign phase_adv  = (phase_sum > (PW+1)'(emp_pkg::PHASE_ONE)) ? emp_pkg::PHASE_ONE
                                                                  : phase_sum[PW-1:0];
   assign phase_in   = (req.func == emp_pkg::FUNC_RESTART) ? '0 : phase_adv;
   assign first_half = (phase_adv <= emp_pkg::PHASE_HALF);
   assign fold_diff  = emp_pkg::PHASE_ONE - phase_adv;

   always_comb begin
      case (curve_mode)
         emp_pkg::CURVE_EASE_OUT: begin
            cos_arg = emp_pkg::PHASE_ONE - phase_adv;
         end
         emp_pkg::CURVE_EASE_IN_OUT: begin
            // fold onto the rising half: 2p, or 2(one - p)
            if (first_half) begin
               cos_arg = {phase_adv[PW-2:0], 1'b0};
            end else begin
               cos_arg = {fold_diff[PW-2:0], 1'b0};
            end
         end
         default: begin
            cos_arg = phase_adv;
         end
      endcase
   end

   emp_cos_rom #(
      .ENTRIES (COS_ENTRIES)
   ) u_cos_rom (
      .angle   (cos_arg),
      .cos_val (cos_val)
   );

   assign half_diff = emp_pkg::PHASE_ONE - cos_val;
   assign half_sum  = {1'b0, emp_pkg::PHASE_ONE} + {1'b0, cos_val};

   always_comb begin
      frac_in.func   = req.func;
      frac_in.moving = (phase_in < emp_pkg::PHASE_ONE);
      case (curve_mode)
         emp_pkg::CURVE_LINEAR: begin
            frac_in.frac = phase_adv;
         end
         emp_pkg::CURVE_EASE_IN: begin
            frac_in.frac = half_diff;
         end
         emp_pkg::CURVE_EASE_OUT: begin
            frac_in.frac = cos_val;
         end
         emp_pkg::CURVE_EASE_IN_OUT: begin
            if (first_half) begin
               frac_in.frac = half_diff >> 1;
            end else begin
               frac_in.frac = half_sum[PW:1];
            end
         end
         default: begin
            frac_in.frac = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frac_ff <= frac_in;
      end
   end

endmodule

// ===== rtl/core/emp_pos_stage.sv =====
// stage two: position and spring speed update, drives the result register
module emp_pos_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              vel_clear,
   input  emp_pkg::cfg_type  cfg,
   input  emp_pkg::frac_type frac,
   output emp_pkg::rsp_type  rsp
);

   localparam int W          = emp_pkg::POS_WIDTH;
   localparam int VW         = emp_pkg::VEL_WIDTH;
   localparam int PW         = emp_pkg::PHASE_WIDTH;
   localparam int F          = emp_pkg::PHASE_FRAC_BITS;
   localparam int PROD_WIDTH = W + PW + 2;
   localparam int SAT_WIDTH  = W + 2;
   localparam int VSUM_WIDTH = VW + 2;
   localparam int DAMP_PROD_WIDTH = VW + emp_pkg::DAMP_WIDTH + 1;

   localparam logic signed [W-1:0]  POS_MAX   = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  POS_MIN   = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [VW-1:0] VEL_MAX   = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VEL_MIN   = {1'b1, {(VW-1){1'b0}}};
   localparam logic [F-1:0]         FRAC_MASK = '1;

   function automatic logic signed [W-1:0] sat_pos(input logic signed [SAT_WIDTH-1:0] v);
      logic signed [W-1:0] r;
      if (v > SAT_WIDTH'(POS_MAX)) begin
         r = POS_MAX;
      end else if (v < SAT_WIDTH'(POS_MIN)) begin
         r = POS_MIN;
      end else begin
         r = v[W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [VW-1:0] sat_vel(input logic signed [VSUM_WIDTH-1:0] v);
      logic signed [VW-1:0] r;
      if (v > VSUM_WIDTH'(VEL_MAX)) begin
         r = VEL_MAX;
      end else if (v < VSUM_WIDTH'(VEL_MIN)) begin
         r = VEL_MIN;
      end else begin
         r = v[VW-1:0];
      end
      return r;
   endfunction

   logic signed [W-1:0]               cur_ff;
   logic signed [W-1:0]               cur_in;
   logic signed [VW-1:0]              vel_ff;
   logic signed [VW-1:0]              vel_in;
   logic                              moving_ff;
   logic signed [W:0]                 span;
   logic signed [W:0]                 remain;
   logic signed [W:0]                 remain_bias;
   logic signed [W:0]                 step8;
   logic signed [PROD_WIDTH-1:0]      lerp_prod;
   logic signed [PROD_WIDTH-1:0]      lerp_bias;
   logic signed [PROD_WIDTH-1:0]      lerp_q;
   logic signed [SAT_WIDTH-1:0]       lerp_pos;
   logic signed [SAT_WIDTH-1:0]       prop_pos;
   logic signed [SAT_WIDTH-1:0]       spring_pos;
   logic signed [VSUM_WIDTH-1:0]      vel_sum;
   logic signed [VW-1:0]              vel_kick;
   logic signed [VW:0]                pos_fix;
   logic signed [VW:0]                pos_bias;
   logic signed [VW:0]                pos_q;
   logic signed [DAMP_PROD_WIDTH-1:0] damp_prod;
   logic signed [DAMP_PROD_WIDTH-1:0] damp_bias;
   logic signed [DAMP_PROD_WIDTH-1:0] damp_q;
   logic signed [VW-1:0]              vel_damped;

   // eased curves: start + trunc(span * frac / one)
   assign span      = (W+1)'($signed(cfg.end_pos)) - (W+1)'($signed(cfg.start_pos));
   assign lerp_prod = PROD_WIDTH'(span) * PROD_WIDTH'($signed({1'b0, frac.frac}));
   assign lerp_bias = lerp_prod[PROD_WIDTH-1] ? PROD_WIDTH'(FRAC_MASK) : '0;
   assign lerp_q    = (lerp_prod + lerp_bias) >>> F;
   assign lerp_pos  = SAT_WIDTH'($signed(cfg.start_pos)) + SAT_WIDTH'($signed(lerp_q[W:0]));

   // one eighth of the remaining distance, toward zero
   assign remain      = (W+1)'($signed(cfg.end_pos)) - (W+1)'(cur_ff);
   assign remain_bias = remain[W] ? (W+1)'(7) : '0;
   assign step8       = (remain + remain_bias) >>> 3;
   assign prop_pos    = SAT_WIDTH'(cur_ff) + SAT_WIDTH'(step8);

   // spring: kick the speed, move by it, then damp it
   assign vel_sum    = VSUM_WIDTH'(vel_ff) + (VSUM_WIDTH'(step8) <<< 8);
   assign vel_kick   = sat_vel(vel_sum);
   assign pos_fix    = ((VW+1)'(cur_ff) <<< 8) + (VW+1)'(vel_kick);
   assign pos_bias   = pos_fix[VW] ? (VW+1)'(255) : '0;
   assign pos_q      = (pos_fix + pos_bias) >>> 8;
   assign spring_pos = SAT_WIDTH'($signed(pos_q[W:0]));

   // damping factor is below one, so the damped speed always fits
   assign damp_prod  = DAMP_PROD_WIDTH'(vel_kick)
                     * DAMP_PROD_WIDTH'($signed({1'b0, cfg.damping}));
   assign damp_bias  = damp_prod[DAMP_PROD_WIDTH-1] ? DAMP_PROD_WIDTH'(255) : '0;
   assign damp_q     = (damp_prod + damp_bias) >>> 8;
   assign vel_damped = damp_q[VW-1:0];

   always_comb begin
      cur_in = cur_ff;
      vel_in = vel_ff;
      if (load) begin
         if (frac.func == emp_pkg::FUNC_RESTART) begin
            cur_in = cfg.start_pos;
            vel_in = '0;
         end else begin
            case (cfg.curve_mode)
               emp_pkg::CURVE_PROPORTIONAL: begin
                  cur_in = sat_pos(prop_pos);
               end
               emp_pkg::CURVE_SPRING: begin
                  cur_in = sat_pos(spring_pos);
                  vel_in = vel_damped;
               end
               default: begin
                  // unused codes hold the position
                  if (cfg.curve_mode inside {emp_pkg::CURVE_LINEAR, emp_pkg::CURVE_EASE_IN,
                                             emp_pkg::CURVE_EASE_OUT,
                                             emp_pkg::CURVE_EASE_IN_OUT}) begin
                     cur_in = sat_pos(lerp_pos);
                  end
               end
            endcase
         end
      end
      if (vel_clear) begin
         vel_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= emp_pkg::START_POS_RESET;
         vel_ff <= '0;
      end else begin
         cur_ff <= cur_in;
         vel_ff <= vel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         moving_ff <= frac.moving;
      end
   end

   assign rsp.position = cur_ff;
   assign rsp.moving   = moving_ff;

endmodule

// ===== rtl/core/easing_motion_profile.sv =====
// top level of the easing motion profile: config registers, pipeline control
//
// One-axis motion generator. Each beat on the req channel is either a tick,
// which adds phase_step to the phase (clamped to one) and moves the position
// along the selected curve, or a restart, which returns to start_pos with
// phase and spring speed at zero. Every req beat yields exactly one rsp beat
// carrying the new position and a moving flag (phase still below one).
// Registers are written through the csr channel (always ready): 0 start_pos,
// 1 end_pos, 2 curve_mode (clears the spring speed), 3 spring_damping. Write
// them only while no beat is in flight.
// Stage one (phase and cosine lookup) registers on the accept edge, and the
// result register loads from it once free. One beat per cycle is sustained
// while rsp_stall is low; the position and speed loop closes in the result
// stage, the phase loop in stage one.
// Reset restores the register defaults, position -384, phase and speed zero,
// and empties the pipeline. When rsp_stall is held, the result register keeps
// its beat, stage one takes one more beat, and then req_stall rises.
`include "assert_macros.svh"

module easing_motion_profile #(
   parameter int COS_TABLE_ENTRIES = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  emp_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output emp_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [emp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [emp_pkg::POS_WIDTH-1:0]        csr_wdata
);

   emp_pkg::cfg_type  cfg_ff;
   emp_pkg::cfg_type  cfg_in;
   emp_pkg::frac_type s1_frac;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              out_free;
   logic              s1_move;
   logic              req_accept;
   logic              csr_write;
   logic              vel_clear;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign vel_clear = csr_write && (csr_index == emp_pkg::CSR_CURVE_MODE);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            emp_pkg::CSR_START_POS: begin
               cfg_in.start_pos = csr_wdata;
            end
            emp_pkg::CSR_END_POS: begin
               cfg_in.end_pos = csr_wdata;
            end
            emp_pkg::CSR_CURVE_MODE: begin
               cfg_in.curve_mode = csr_wdata[emp_pkg::MODE_WIDTH-1:0];
            end
            emp_pkg::CSR_DAMPING: begin
               cfg_in.damping = csr_wdata[emp_pkg::DAMP_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_pos  <= emp_pkg::START_POS_RESET;
         cfg_ff.end_pos    <= emp_pkg::END_POS_RESET;
         cfg_ff.curve_mode <= emp_pkg::CURVE_RESET;
         cfg_ff.damping    <= emp_pkg::DAMPING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // two-entry pipeline: stage one keeps a beat while the result waits
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_move      = s1_valid_ff && out_free;
   assign req_stall    = s1_valid_ff && !out_free;
   assign req_accept   = req_valid && !req_stall;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   emp_phase_stage #(
      .COS_ENTRIES (COS_TABLE_ENTRIES)
   ) u_phase_stage (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .req        (req_data),
      .curve_mode (cfg_ff.curve_mode),
      .frac_ff    (s1_frac)
   );

   emp_pos_stage u_pos_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_move),
      .vel_clear (vel_clear),
      .cfg       (cfg_ff),
      .frac      (s1_frac),
      .rsp       (rsp_data)
   );

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_PROP(a_rsp_from_stage_one, clock, reset, $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
   `ASSERT_PROP(a_stall_keeps_beats, clock, reset, s1_valid_ff && rsp_valid_ff && rsp_stall |=> s1_valid_ff && rsp_valid_ff)
   `ASSERT_NEVER(a_restart_moving, clock, reset, s1_valid_ff && s1_frac.func == emp_pkg::FUNC_RESTART && !s1_frac.moving)

endmodule

// ===== tb/motion_profile_checker.sv =====
// checker for the easing motion profile: watches the channels, predicts positions, compares
`timescale 1ns / 1ps

module motion_profile_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  emp_pkg::req_type                    req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  emp_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [emp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [emp_pkg::POS_WIDTH-1:0]       csr_wdata,
   output int                                  fail_count,
   output int                                  pending
);
   import emp_pkg::*;

   localparam int     COS_ENTRIES  = 256;
   localparam int     REPORT_LIMIT = 200;
   localparam longint ONE          = longint'(1) << PHASE_FRAC_BITS;
   localparam longint POS_HI       = (longint'(1) << (POS_WIDTH - 1)) - 1;
   localparam longint POS_LO       = -(longint'(1) << (POS_WIDTH - 1));
   localparam longint VEL_HI       = (longint'(1) << (VEL_WIDTH - 1)) - 1;
   localparam longint VEL_LO       = -(longint'(1) << (VEL_WIDTH - 1));
   localparam longint SPEED_ONE    = 256;
   localparam longint PULL_DIV     = 8;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   longint cos_rom [0:COS_ENTRIES];

   longint                start_r, end_r, damp_r;
   logic [MODE_WIDTH-1:0] mode_r;
   longint                phase_r, pos_r, vel_r;

   rsp_type expected_positions [$];

   // quarter-wave cosine in Q1.16, from a 13-term series on Q2.30 magnitudes
   initial begin
      longint unsigned k_u, x, x2, term;
      longint          acc, e;
      for (int k = 0; k <= COS_ENTRIES; k++) begin
         k_u  = k;
         x    = (HALF_PI_Q30 * k_u) / COS_ENTRIES;
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         acc  = longint'(term);
         for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         e = (acc + (longint'(1) << (29 - PHASE_FRAC_BITS))) >> (30 - PHASE_FRAC_BITS);
         cos_rom[k] = (e > ONE) ? ONE : e;
      end
   end

   function automatic longint saturate(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint cos_lookup(input longint u);
      longint idx;
      idx = (u * COS_ENTRIES + ONE / 2) >> PHASE_FRAC_BITS;
      if (idx > COS_ENTRIES) begin
         idx = COS_ENTRIES;
      end
      return cos_rom[idx];
   endfunction

   function automatic void write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                          input logic [POS_WIDTH-1:0] value);
      case (idx)
         CSR_START_POS: begin
            start_r = $signed(value);
         end
         CSR_END_POS: begin
            end_r = $signed(value);
         end
         CSR_CURVE_MODE: begin
            mode_r = value[MODE_WIDTH-1:0];
            vel_r  = 0;
         end
         CSR_DAMPING: begin
            damp_r = value[DAMP_WIDTH-1:0];
         end
         default: ;
      endcase
   endfunction

   // advances the motion state by one beat and returns the position it should report
   function automatic rsp_type advance_motion(input req_type beat);
      longint  f;
      rsp_type r;
      f = -1;
      if (beat.func == FUNC_RESTART) begin
         pos_r   = start_r;
         phase_r = 0;
         vel_r   = 0;
      end else begin
         phase_r = phase_r + longint'(beat.phase_step);
         if (phase_r > ONE) begin
            phase_r = ONE;
         end
         case (mode_r)
            CURVE_LINEAR: begin
               f = phase_r;
            end
            CURVE_EASE_IN: begin
               f = ONE - cos_lookup(phase_r);
            end
            CURVE_EASE_OUT: begin
               f = cos_lookup(ONE - phase_r);
            end
            CURVE_EASE_IN_OUT: begin
               if (phase_r <= ONE / 2) begin
                  f = (ONE - cos_lookup(2 * phase_r)) / 2;
               end else begin
                  f = (ONE + cos_lookup(2 * ONE - 2 * phase_r)) / 2;
               end
            end
            CURVE_PROPORTIONAL: begin
               pos_r = saturate(pos_r + (end_r - pos_r) / PULL_DIV, POS_LO, POS_HI);
            end
            CURVE_SPRING: begin
               vel_r = saturate(vel_r + ((end_r - pos_r) / PULL_DIV) * SPEED_ONE,
                                VEL_LO, VEL_HI);
               pos_r = saturate((pos_r * SPEED_ONE + vel_r) / SPEED_ONE, POS_LO, POS_HI);
               vel_r = saturate((vel_r * damp_r) / SPEED_ONE, VEL_LO, VEL_HI);
            end
            default: ;
         endcase
         if (f >= 0) begin
            pos_r = saturate(start_r + ((end_r - start_r) * f) / ONE, POS_LO, POS_HI);
         end
      end
      r.position = pos_r[POS_WIDTH-1:0];
      r.moving   = (phase_r < ONE);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input longint want, input longint got);
      if (fail_count < REPORT_LIMIT) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         start_r    = START_POS_RESET;
         end_r      = END_POS_RESET;
         mode_r     = CURVE_RESET;
         damp_r     = DAMPING_RESET;
         phase_r    = 0;
         pos_r      = START_POS_RESET;
         vel_r      = 0;
         fail_count = 0;
         expected_positions.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            write_register(csr_index, csr_wdata);
         end
         // check the outgoing beat before queuing the incoming one
         if (rsp_valid && !rsp_stall) begin
            if (expected_positions.size() == 0) begin
               if (fail_count < REPORT_LIMIT) begin
                  $display("%0t ns: result beat with nothing expected, got position %0d moving %0b",
                           $time, $signed(rsp_data.position), rsp_data.moving);
               end
               fail_count++;
            end else begin
               want = expected_positions.pop_front();
               if (rsp_data.position !== want.position) begin
                  note_mismatch("position", $signed(want.position), $signed(rsp_data.position));
               end
               if (rsp_data.moving !== want.moving) begin
                  note_mismatch("moving", want.moving, rsp_data.moving);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_positions.insert(expected_positions.size(), advance_motion(req_data));
         end
      end
      pending <= expected_positions.size();
   end

endmodule

// ===== tb/easing_motion_profile_test.sv =====
// top of the easing motion profile testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module easing_motion_profile_test;
   import emp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 438;

   localparam logic [MODE_WIDTH-1:0] CURVE_SPARE_A = 3'd6;
   localparam logic [MODE_WIDTH-1:0] CURVE_SPARE_B = 3'd7;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   req_type                    req_data  = '0;
   logic                       rsp_stall = 1'b0;
   logic                       csr_valid = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [POS_WIDTH-1:0]       csr_wdata = '0;

   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_ready;

   int fail_count;
   int pending;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int cycle_count = 0;

   easing_motion_profile dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   motion_profile_checker profile_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // one beat on the req channel; valid stays up across back-to-back beats
   task automatic send_item(input logic func, input logic [PHASE_FRAC_BITS-1:0] step);
      req_type item;
      item.func       = func;
      item.phase_step = step;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // drop valid and let every expected result come back before touching registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [POS_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic write_regs(input logic [3:0] mask, input logic [POS_WIDTH-1:0] start_v,
                             input logic [POS_WIDTH-1:0] end_v, input logic [POS_WIDTH-1:0] mode_v,
                             input logic [POS_WIDTH-1:0] damp_v);
      if (mask[CSR_START_POS]) begin
         csr_beat(CSR_START_POS, start_v);
      end
      if (mask[CSR_END_POS]) begin
         csr_beat(CSR_END_POS, end_v);
      end
      if (mask[CSR_CURVE_MODE]) begin
         csr_beat(CSR_CURVE_MODE, mode_v);
      end
      if (mask[CSR_DAMPING]) begin
         csr_beat(CSR_DAMPING, damp_v);
      end
      csr_valid <= 1'b0;
   endtask

   // unused upper bits of the narrow registers get junk now and then
   function automatic logic [POS_WIDTH-1:0] mode_word(input logic [MODE_WIDTH-1:0] m);
      logic [POS_WIDTH-1:0] w;
      w = ($urandom_range(3) == 0) ? POS_WIDTH'($urandom) : '0;
      w[MODE_WIDTH-1:0] = m;
      return w;
   endfunction

   function automatic logic [POS_WIDTH-1:0] damp_word(input logic [DAMP_WIDTH-1:0] d);
      logic [POS_WIDTH-1:0] w;
      w = ($urandom_range(3) == 0) ? POS_WIDTH'($urandom) : '0;
      w[DAMP_WIDTH-1:0] = d;
      return w;
   endfunction

   function automatic logic [POS_WIDTH-1:0] pick_pos();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return '0;
         3, 4: return POS_WIDTH'($urandom_range(0, 2047)) - 16'd1024;
         default: return POS_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [DAMP_WIDTH-1:0] pick_damping();
      case ($urandom_range(5))
         0: return '0;
         1: return 8'hFF;
         2: return DAMPING_RESET;
         default: return DAMP_WIDTH'($urandom);
      endcase
   endfunction

   task automatic run_directed();
      // reset settings: linear from -384 to 384, phase runs up to one and clamps
      send_item(FUNC_RESTART, '0);
      send_item(FUNC_TICK, '0);
      send_item(FUNC_TICK, 16'hFFFF);
      send_item(FUNC_TICK, 16'h0001);
      send_item(FUNC_TICK, 16'hFFFF);
      wait_idle();
      // full-range ease in/out across the half point
      write_regs(4'b0111, 16'h8000, 16'h7FFF, mode_word(CURVE_EASE_IN_OUT), '0);
      send_item(FUNC_RESTART, 16'hFFFF);
      send_item(FUNC_TICK, 16'h8000);
      send_item(FUNC_TICK, 16'h0001);
      send_item(FUNC_TICK, 16'h7FFF);
      wait_idle();
      write_regs(4'b0100, '0, '0, 16'hFFF8 | CURVE_EASE_IN, '0);
      send_item(FUNC_RESTART, '0);
      send_item(FUNC_TICK, 16'h4000);
      send_item(FUNC_TICK, 16'hC000);
      wait_idle();
      write_regs(4'b0100, '0, '0, mode_word(CURVE_EASE_OUT), '0);
      send_item(FUNC_RESTART, '0);
      send_item(FUNC_TICK, 16'h4000);
      wait_idle();
      write_regs(4'b0100, '0, '0, mode_word(CURVE_PROPORTIONAL), '0);
      send_item(FUNC_RESTART, '0);
      send_item(FUNC_TICK, 16'h0100);
      wait_idle();
      // spring with the weakest damping (255/256) overshoots into the top rail
      write_regs(4'b1100, '0, '0, mode_word(CURVE_SPRING), 16'hFFFF);
      send_item(FUNC_RESTART, '0);
      repeat (4) send_item(FUNC_TICK, 16'h1000);
      wait_idle();
      // new target mid-flight keeps the speed
      write_regs(4'b0010, '0, 16'h8000, '0, '0);
      repeat (2) send_item(FUNC_TICK, 16'h1000);
      wait_idle();
      write_regs(4'b0100, '0, '0, 16'h5556 | CURVE_SPARE_A, '0);
      send_item(FUNC_TICK, 16'h2000);
      wait_idle();
      write_regs(4'b0100, '0, '0, mode_word(CURVE_SPARE_B), '0);
      send_item(FUNC_TICK, 16'h2000);
      wait_idle();
   endtask

   task automatic run_random(input int n_items);
      int                    sent;
      int                    seg_left;
      int                    roll;
      logic [15:0]           step_cap;
      logic [MODE_WIDTH-1:0] mode;
      logic [3:0]            mask;
      sent = 0;
      while (sent < n_items) begin
         wait_idle();
         mask = ($urandom_range(3) == 0) ? 4'hF : 4'($urandom_range(1, 15));
         mode = ($urandom_range(9) == 0) ? MODE_WIDTH'($urandom_range(6, 7))
                                         : MODE_WIDTH'($urandom_range(0, 5));
         write_regs(mask, pick_pos(), pick_pos(), mode_word(mode), damp_word(pick_damping()));
         case ($urandom_range(3))
            0: step_cap = 16'h00FF;
            1: step_cap = 16'h0FFF;
            2: step_cap = 16'h3FFF;
            default: step_cap = 16'hFFFF;
         endcase
         seg_left = $urandom_range(20, 60);
         if ($urandom_range(3) != 0) begin
            send_item(FUNC_RESTART, PHASE_FRAC_BITS'($urandom));
            sent++;
         end
         while (seg_left > 0 && sent < n_items) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
               send_item(FUNC_RESTART, PHASE_FRAC_BITS'($urandom));
            end else if (roll < 8) begin
               send_item(FUNC_TICK, '0);
            end else if (roll < 11) begin
               send_item(FUNC_TICK, 16'hFFFF);
            end else begin
               send_item(FUNC_TICK, PHASE_FRAC_BITS'($urandom_range(0, step_cap)));
            end
            sent++;
            seg_left--;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      idle_pct  = 0;
      stall_pct = 0;
      run_random(PHASE_ITEMS);
      idle_pct  = 57;
      stall_pct = 0;
      run_random(PHASE_ITEMS);
      idle_pct  = 0;
      stall_pct = 57;
      run_random(PHASE_ITEMS);
      idle_pct  = 17;
      stall_pct = 17;
      run_random(PHASE_ITEMS);
      wait_idle();
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
